@@ src/ttc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal package
// Shared types and codes of the text terminal controller.
// ----------------------------------------------------------------------------
package ttc_pkg;

  typedef enum logic [2:0] {
    PS_START, PS_BRACKET, PS_BRACKET_SEMI, PS_NUM1, PS_NUM1_SEMI, PS_NUM2
  } parse_e;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_MATCH, ST_FAIL} esc_status_e;

  typedef enum logic [2:0] {
    FS_IDLE, FS_CLEAR, FS_READ, FS_SCROLL_RD, FS_SCROLL_WR, FS_FILL, FS_DONE
  } fsm_e;

  localparam logic [4:0] C_CUP = 5'd0;
  localparam logic [4:0] C_CUU = 5'd1;
  localparam logic [4:0] C_CUD = 5'd2;
  localparam logic [4:0] C_CUF = 5'd3;
  localparam logic [4:0] C_CUB = 5'd4;
  localparam logic [4:0] C_HOME = 5'd5;
  localparam logic [4:0] C_NEL = 5'd6;
  localparam logic [4:0] C_SAVE = 5'd7;
  localparam logic [4:0] C_RESTORE = 5'd8;
  localparam logic [4:0] C_RIS = 5'd9;
  localparam logic [4:0] C_IND = 5'd10;
  localparam logic [4:0] C_RI = 5'd11;
  localparam logic [4:0] C_DECSTBM = 5'd12;
  localparam logic [4:0] C_ED0 = 5'd13;
  localparam logic [4:0] C_EL0 = 5'd16;
  localparam logic [4:0] C_SGR0 = 5'd17;

  localparam logic [7:0] ESC_CODE = 8'h1B;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] TILDE_CODE = 8'h7E;
  localparam logic [7:0] NL_CODE = 8'h0A;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [1:0]  escape_status;
    logic [4:0]  matched_command;
  } result_t;

endpackage

@@ src/ttc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one host transaction.
// ----------------------------------------------------------------------------
interface ttc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  char_code;
  logic [10:0] cell_address;
  modport source (output valid, command, char_code, cell_address, input ready);
  modport sink (input valid, command, char_code, cell_address, output ready);
endinterface

@@ src/ttc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface ttc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [7:0]  cell_char;
  logic [1:0]  escape_status;
  logic [4:0]  matched_command;
  modport source (output valid, cursor_position, cell_char, escape_status,
                  matched_command, input ready);
  modport sink (input valid, cursor_position, cell_char, escape_status,
                matched_command, output ready);
endinterface

@@ src/ttc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape parser
// Combinational next-state of the VT100 escape sequence parser.
// ----------------------------------------------------------------------------
module ttc_parser (
  input  ttc_pkg::parse_e      state_i,
  input  logic [7:0]           key_i,
  input  logic [7:0]           num1_i,
  input  logic [7:0]           num2_i,
  output ttc_pkg::parse_e      state_o,
  output logic [7:0]           num1_o,
  output logic [7:0]           num2_o,
  output ttc_pkg::esc_status_e status_o,
  output logic [4:0]           code_o
);

  logic       is_dig;
  logic [3:0] dig;
  logic [11:0] acc1, acc2;

  assign is_dig = (key_i >= 8'h30) && (key_i <= 8'h39);
  assign dig = key_i[3:0];
  // decimal accumulate with saturation at 255
  assign acc1 = {1'b0, num1_i, 3'b0} + {3'b0, num1_i, 1'b0} + {8'b0, dig};
  assign acc2 = {1'b0, num2_i, 3'b0} + {3'b0, num2_i, 1'b0} + {8'b0, dig};

  always_comb begin
    state_o = state_i;
    num1_o = num1_i;
    num2_o = num2_i;
    status_o = ttc_pkg::ST_FAIL;
    code_o = 5'd0;
    unique case (state_i)
      ttc_pkg::PS_START: begin
        status_o = ttc_pkg::ST_MATCH;
        case (key_i)
          8'h5B: begin state_o = ttc_pkg::PS_BRACKET; status_o = ttc_pkg::ST_BUSY; end
          8'h63: code_o = ttc_pkg::C_RIS;
          8'h44: code_o = ttc_pkg::C_IND;
          8'h45: code_o = ttc_pkg::C_NEL;
          8'h4D: code_o = ttc_pkg::C_RI;
          8'h37: code_o = ttc_pkg::C_SAVE;
          8'h38: code_o = ttc_pkg::C_RESTORE;
          default: status_o = ttc_pkg::ST_FAIL;
        endcase
      end
      ttc_pkg::PS_BRACKET: begin
        status_o = ttc_pkg::ST_MATCH;
        if (is_dig) begin
          num1_o = {4'd0, dig}; state_o = ttc_pkg::PS_NUM1; status_o = ttc_pkg::ST_BUSY;
        end else begin
          case (key_i)
            8'h3B: begin state_o = ttc_pkg::PS_BRACKET_SEMI; status_o = ttc_pkg::ST_BUSY; end
            8'h48, 8'h66: code_o = ttc_pkg::C_HOME;
            8'h4A: code_o = ttc_pkg::C_ED0;
            8'h4B: code_o = ttc_pkg::C_EL0;
            8'h6D: code_o = ttc_pkg::C_SGR0;
            default: status_o = ttc_pkg::ST_FAIL;
          endcase
        end
      end
      ttc_pkg::PS_BRACKET_SEMI: begin
        if (key_i == 8'h48 || key_i == 8'h66) begin
          status_o = ttc_pkg::ST_MATCH; code_o = ttc_pkg::C_HOME;
        end
      end
      ttc_pkg::PS_NUM1: begin
        status_o = ttc_pkg::ST_MATCH;
        if (is_dig) begin
          num1_o = (acc1 > 12'd255) ? 8'd255 : acc1[7:0];
          status_o = ttc_pkg::ST_BUSY;
        end else begin
          case (key_i)
            8'h3B: begin state_o = ttc_pkg::PS_NUM1_SEMI; status_o = ttc_pkg::ST_BUSY; end
            8'h41: code_o = ttc_pkg::C_CUU;
            8'h42: code_o = ttc_pkg::C_CUD;
            8'h43: code_o = ttc_pkg::C_CUF;
            8'h44: code_o = ttc_pkg::C_CUB;
            8'h4A: begin
              if (num1_i >= 8'd3) status_o = ttc_pkg::ST_FAIL;
              else code_o = ttc_pkg::C_ED0 + num1_i[4:0];
            end
            8'h6D: begin
              if (num1_i == 8'd3 || num1_i > 8'd8) status_o = ttc_pkg::ST_FAIL;
              else code_o = ttc_pkg::C_SGR0 + num1_i[4:0];
            end
            default: status_o = ttc_pkg::ST_FAIL;
          endcase
        end
      end
      ttc_pkg::PS_NUM1_SEMI: begin
        if (is_dig) begin
          num2_o = {4'd0, dig}; state_o = ttc_pkg::PS_NUM2; status_o = ttc_pkg::ST_BUSY;
        end
      end
      ttc_pkg::PS_NUM2: begin
        status_o = ttc_pkg::ST_MATCH;
        if (is_dig) begin
          num2_o = (acc2 > 12'd255) ? 8'd255 : acc2[7:0];
          status_o = ttc_pkg::ST_BUSY;
        end else begin
          case (key_i)
            8'h72: code_o = ttc_pkg::C_DECSTBM;
            8'h48, 8'h66: code_o = ttc_pkg::C_CUP;
            default: status_o = ttc_pkg::ST_FAIL;
          endcase
        end
      end
      default: status_o = ttc_pkg::ST_FAIL;
    endcase
  end

endmodule

@@ src/text_terminal_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal controller
// VT100-style character screen with cursor and escape parser.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one transaction per item: command 0 sends a host byte,
// command 1 reads one screen cell. out_ch returns exactly one result per item.
// One item at a time: in_ch.ready is high only while the sequencer is idle.
// A read, or a send that leaves the cursor alone, raises out_ch.valid from
// DONE after one memory read and the result register. A send that moves the
// cursor holds the result in DONE while the column register is rebuilt by
// repeated subtraction of COLUMNS.
// A printable byte that steps past the last cell, or a NEL on the last row,
// scrolls the screen: the screen memory, with one read and one write port,
// copies COLUMNS*(ROWS-1) cells, reading in SCROLL_RD and writing in
// SCROLL_WR, and then blanks COLUMNS cells.
// After reset a clearing pass writes space into all ROWS*COLUMNS cells, one
// per cycle; no item is accepted meanwhile.
// When the receiver stalls the result waits in the output register and the
// next item is not taken until the result is delivered.
// ----------------------------------------------------------------------------
module text_terminal_controller_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 24
) (
  input logic       clk_i,
  input logic       rst_ni,
  ttc_in_if.sink    in_ch,
  ttc_out_if.source out_ch
);

  localparam int Size = COLUMNS * ROWS;
  localparam int Aw = 11;
  localparam logic [Aw-1:0] SizeA = Aw'(Size);
  localparam logic [Aw-1:0] ColsA = Aw'(COLUMNS);
  localparam logic [Aw-1:0] LastRow = Aw'(Size - COLUMNS);

  // screen memory
  logic [7:0] mem_q [Size];
  logic       mem_we;
  logic [Aw-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[mem_ra];
  end

  ttc_pkg::fsm_e fsm_q, fsm_d;
  logic [Aw-1:0] ptr_q, ptr_d;
  logic [Aw-1:0] cur_q, cur_d, sav_q, sav_d;
  logic          sav_v_q, sav_v_d, esc_q, esc_d;
  ttc_pkg::parse_e ps_q, ps_d;
  logic [7:0]    n1_q, n1_d, n2_q, n2_d;
  ttc_pkg::result_t res_q, res_d;
  logic          ovalid_q, ovalid_d;
  logic [7:0]    key_q;
  logic          cmd_q;
  logic [Aw-1:0] addr_q;
  logic [Aw-1:0] col_q; // column of cursor, rebuilt by repeated subtraction
  logic          scroll_req;

  // parser
  ttc_pkg::parse_e p_state;
  logic [7:0] p_n1, p_n2;
  ttc_pkg::esc_status_e p_status;
  logic [4:0] p_code;

  ttc_parser u_parser (
    .state_i(ps_q), .key_i(key_q), .num1_i(n1_q), .num2_i(n2_q),
    .state_o(p_state), .num1_o(p_n1), .num2_o(p_n2),
    .status_o(p_status), .code_o(p_code)
  );

  // cursor move targets (signed, wide enough for v1*COLUMNS)
  logic signed [17:0] v1c, tgt;
  logic [Aw-1:0] nel_tgt;
  logic          in_rng;
  assign v1c = 18'(n1_q) * 18'(COLUMNS);
  assign nel_tgt = cur_q + ColsA - col_q;

  always_comb begin
    tgt = 18'sd0;
    case (p_code)
      ttc_pkg::C_CUP: tgt = v1c + 18'(n2_q);
      ttc_pkg::C_CUU: tgt = 18'(cur_q) - v1c;
      ttc_pkg::C_CUD: tgt = 18'(cur_q) + v1c;
      ttc_pkg::C_CUF: tgt = 18'(cur_q) + 18'(n1_q);
      ttc_pkg::C_CUB: tgt = 18'(cur_q) - 18'(n1_q);
      default: tgt = 18'sd0;
    endcase
  end
  assign in_rng = (tgt >= 0) && (tgt < 18'(Size));

  // column of a target is computed by repeated subtraction of COLUMNS;
  // FS_DONE waits while this small divider sequence runs, and a separate
  // column register keeps the result between moves.
  logic          col_busy_q, col_busy_d;
  logic [Aw-1:0] col_rem_q, col_rem_d;

  // a scroll is needed when the cursor steps past the screen
  always_comb begin
    scroll_req = 1'b0;
    if (fsm_q == ttc_pkg::FS_READ && cmd_q == ttc_pkg::CMD_SEND) begin
      if (esc_q) begin
        scroll_req = (p_status == ttc_pkg::ST_MATCH) && (p_code == ttc_pkg::C_NEL) &&
                     (nel_tgt >= SizeA);
      end else if (key_q >= ttc_pkg::SPACE_CODE && key_q <= ttc_pkg::TILDE_CODE) begin
        scroll_req = (cur_q == SizeA - 1'b1);
      end
    end
  end

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ttc_pkg::FS_CLEAR: if (ptr_q == SizeA - 1'b1) fsm_d = ttc_pkg::FS_IDLE;
      ttc_pkg::FS_IDLE: if (in_ch.valid && !ovalid_q) fsm_d = ttc_pkg::FS_READ;
      ttc_pkg::FS_READ: fsm_d = scroll_req ? ttc_pkg::FS_SCROLL_RD : ttc_pkg::FS_DONE;
      ttc_pkg::FS_SCROLL_RD: fsm_d = ttc_pkg::FS_SCROLL_WR;
      ttc_pkg::FS_SCROLL_WR:
        fsm_d = (ptr_q == LastRow - 1'b1) ? ttc_pkg::FS_FILL : ttc_pkg::FS_SCROLL_RD;
      ttc_pkg::FS_FILL: if (ptr_q == SizeA - 1'b1) fsm_d = ttc_pkg::FS_DONE;
      ttc_pkg::FS_DONE: fsm_d = col_busy_q ? ttc_pkg::FS_DONE : ttc_pkg::FS_IDLE;
      default: fsm_d = ttc_pkg::FS_IDLE;
    endcase
  end

  // datapath / outputs
  always_comb begin
    ptr_d = ptr_q; cur_d = cur_q; sav_d = sav_q; sav_v_d = sav_v_q;
    esc_d = esc_q; ps_d = ps_q; n1_d = n1_q; n2_d = n2_q;
    res_d = res_q; ovalid_d = ovalid_q;
    col_busy_d = col_busy_q; col_rem_d = col_rem_q;
    mem_we = 1'b0; mem_wa = ptr_q; mem_wd = ttc_pkg::SPACE_CODE;
    mem_ra = ptr_q + ColsA;
    if (ovalid_q && out_ch.ready) ovalid_d = 1'b0;
    // column tracking by repeated subtraction of COLUMNS
    if (col_busy_q) begin
      if (col_rem_q >= ColsA) col_rem_d = col_rem_q - ColsA;
      else col_busy_d = 1'b0;
    end
    unique case (fsm_q)
      ttc_pkg::FS_CLEAR: begin
        mem_we = 1'b1; ptr_d = ptr_q + 1'b1;
      end
      ttc_pkg::FS_IDLE: begin
        mem_ra = in_ch.cell_address;
      end
      ttc_pkg::FS_READ: begin
        res_d = '0;
        res_d.cursor_position = cur_q;
        ptr_d = '0;
        if (cmd_q == ttc_pkg::CMD_READ) begin
          res_d.cell_char = (addr_q < SizeA) ? mem_rd_q : 8'd0;
          res_d.escape_status = esc_q ? ttc_pkg::ST_BUSY : ttc_pkg::ST_IDLE;
        end else if (esc_q) begin
          res_d.escape_status = p_status;
          ps_d = p_state; n1_d = p_n1; n2_d = p_n2;
          if (p_status != ttc_pkg::ST_BUSY) begin
            esc_d = 1'b0; ps_d = ttc_pkg::PS_START;
          end
          if (p_status == ttc_pkg::ST_MATCH) begin
            res_d.matched_command = p_code;
            case (p_code)
              ttc_pkg::C_CUP, ttc_pkg::C_CUU, ttc_pkg::C_CUD,
              ttc_pkg::C_CUF, ttc_pkg::C_CUB:
                if (in_rng) begin
                  cur_d = tgt[Aw-1:0]; col_busy_d = 1'b1; col_rem_d = tgt[Aw-1:0];
                end
              ttc_pkg::C_HOME: begin cur_d = '0; col_busy_d = 1'b1; col_rem_d = '0; end
              ttc_pkg::C_NEL: begin
                if (nel_tgt >= SizeA) cur_d = LastRow;
                else cur_d = nel_tgt;
                col_busy_d = 1'b1; col_rem_d = '0;
              end
              ttc_pkg::C_SAVE: begin sav_d = cur_q; sav_v_d = 1'b1; end
              ttc_pkg::C_RESTORE:
                if (sav_v_q) begin
                  cur_d = sav_q; sav_v_d = 1'b0; col_busy_d = 1'b1; col_rem_d = sav_q;
                end
              default: ;
            endcase
          end
        end else if (key_q == ttc_pkg::ESC_CODE) begin
          esc_d = 1'b1; ps_d = ttc_pkg::PS_START; n1_d = '0; n2_d = '0;
          res_d.escape_status = ttc_pkg::ST_BUSY;
        end else if (key_q >= ttc_pkg::SPACE_CODE && key_q <= ttc_pkg::TILDE_CODE) begin
          mem_we = 1'b1; mem_wa = cur_q; mem_wd = key_q;
          col_busy_d = 1'b1;
          if (cur_q == SizeA - 1'b1) begin
            cur_d = LastRow; col_rem_d = '0;
          end else begin
            cur_d = cur_q + 1'b1; col_rem_d = cur_q + 1'b1;
          end
        end else if (key_q == ttc_pkg::NL_CODE) begin
          if (nel_tgt < SizeA) begin
            cur_d = nel_tgt; col_busy_d = 1'b1; col_rem_d = '0;
          end
        end
        res_d.cursor_position = cur_d;
      end
      ttc_pkg::FS_SCROLL_RD: mem_ra = ptr_q + ColsA;
      ttc_pkg::FS_SCROLL_WR: begin
        mem_we = 1'b1; mem_wd = mem_rd_q; ptr_d = ptr_q + 1'b1;
        mem_ra = ptr_q + 1'b1 + ColsA;
      end
      ttc_pkg::FS_FILL: begin
        mem_we = 1'b1; ptr_d = ptr_q + 1'b1;
      end
      ttc_pkg::FS_DONE: if (!col_busy_q) ovalid_d = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = (fsm_q == ttc_pkg::FS_IDLE) && !ovalid_q;
  assign out_ch.valid = ovalid_q;
  assign out_ch.cursor_position = res_q.cursor_position;
  assign out_ch.cell_char = res_q.cell_char;
  assign out_ch.escape_status = res_q.escape_status;
  assign out_ch.matched_command = res_q.matched_command;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= ttc_pkg::FS_CLEAR;
      ptr_q <= '0; cur_q <= '0; sav_q <= '0; sav_v_q <= 1'b0; esc_q <= 1'b0;
      ps_q <= ttc_pkg::PS_START; n1_q <= '0; n2_q <= '0;
      ovalid_q <= 1'b0; col_busy_q <= 1'b0; col_rem_q <= '0; col_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      ptr_q <= ptr_d; cur_q <= cur_d; sav_q <= sav_d; sav_v_q <= sav_v_d;
      esc_q <= esc_d; ps_q <= ps_d; n1_q <= n1_d; n2_q <= n2_d;
      ovalid_q <= ovalid_d; col_busy_q <= col_busy_d; col_rem_q <= col_rem_d;
      if (col_busy_q && col_rem_q < ColsA) col_q <= col_rem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_ch.valid && in_ch.ready) begin
      key_q <= in_ch.char_code; cmd_q <= in_ch.command; addr_q <= in_ch.cell_address;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != ttc_pkg::FS_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q < SizeA) else $error("cursor out of range");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ttc_pkg::FS_DONE && !col_busy_q) |=> ovalid_q)
    else $error("result not raised");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < ColsA) else $error("column out of range");
`endif

endmodule
